/* hw/rtl/qrk_pkg.sv */
// ----------------------------------------------------------------------------
// qrk_pkg: shared types for the quaternion RK4 integrator
// Word types used by the channel interfaces and the integrator core.
// ----------------------------------------------------------------------------
package qrk_pkg;

  typedef logic signed [31:0] qword_t;
  typedef logic        [31:0] tstep_t;

  // item commands
  localparam logic CMD_STEP = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

endpackage

/* hw/rtl/qrk_in_if.sv */
// ----------------------------------------------------------------------------
// qrk_in_if: input item channel
// Valid/ready channel carrying the command, rate quaternion and time step.
// ----------------------------------------------------------------------------
interface qrk_in_if;
  logic            valid;
  logic            ready;
  logic            cmd;
  qrk_pkg::qword_t rate_w0;
  qrk_pkg::qword_t rate_w1;
  qrk_pkg::qword_t rate_w2;
  qrk_pkg::qword_t rate_w3;
  qrk_pkg::tstep_t step_time;

  modport source (
    output valid, cmd, rate_w0, rate_w1, rate_w2, rate_w3, step_time,
    input  ready
  );
  modport sink (
    input  valid, cmd, rate_w0, rate_w1, rate_w2, rate_w3, step_time,
    output ready
  );
endinterface

/* hw/rtl/qrk_out_if.sv */
// ----------------------------------------------------------------------------
// qrk_out_if: result item channel
// Valid/ready channel carrying the updated quaternion and the saturation flag.
// ----------------------------------------------------------------------------
interface qrk_out_if;
  logic            valid;
  logic            ready;
  qrk_pkg::qword_t out_q0;
  qrk_pkg::qword_t out_q1;
  qrk_pkg::qword_t out_q2;
  qrk_pkg::qword_t out_q3;
  logic            saturated;

  modport source (
    output valid, out_q0, out_q1, out_q2, out_q3, saturated,
    input  ready
  );
  modport sink (
    input  valid, out_q0, out_q1, out_q2, out_q3, saturated,
    output ready
  );
endinterface

/* hw/rtl/quaternion_rk4_integrator_top.sv */
// ----------------------------------------------------------------------------
// quaternion_rk4_integrator_top: quaternion attitude RK4 integrator
// Keeps a Q2.30 attitude quaternion; loads it or advances it one RK4 step.
// ----------------------------------------------------------------------------
// One item at a time. A load item (cmd 1) returns in the cycle after it is taken.
// An integration item runs on a single shared 33x33 multiplier under a
// sequencer, followed by a radix-4 divide by six and, with renormalization on,
// by a 2-bit per cycle square root and a 1-bit per cycle restoring divider.
// in_chan.ready is high only while the block is idle; the result stays on
// out_chan until taken.
module quaternion_rk4_integrator_top #(
  parameter int FRAC_BITS = 30
) (
  input  logic      clk,
  input  logic      rst_n,
  qrk_in_if.sink    in_chan,
  qrk_out_if.source out_chan,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data
);
  import qrk_pkg::*;

  localparam int ACC_W = 76;
  localparam int K_W   = 40;
  localparam int KS_W  = 42;
  localparam int P_W   = 66;
  localparam int NUM_W = 32 + FRAC_BITS - 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DER  = 4'd1;
  localparam logic [3:0] S_KFIN = 4'd2;
  localparam logic [3:0] S_MD   = 4'd3;
  localparam logic [3:0] S_TFIN = 4'd4;
  localparam logic [3:0] S_D6I  = 4'd5;
  localparam logic [3:0] S_D6   = 4'd6;
  localparam logic [3:0] S_QFIN = 4'd7;
  localparam logic [3:0] S_SQ   = 4'd8;
  localparam logic [3:0] S_SQRT = 4'd9;
  localparam logic [3:0] S_DCHK = 4'd10;
  localparam logic [3:0] S_DIV  = 4'd11;
  localparam logic [3:0] S_DFIN = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  // subtract flags of q*w, indexed by {component, term}
  localparam logic [15:0] DER_NEG  = 16'h428E;
  localparam logic [43:0] D6_BIAS  = 44'd6 << 40;
  localparam logic [43:0] D6_QOFF  = 44'd1 << 40;
  localparam qword_t      Q_MAX    = 32'sh7FFF_FFFF;
  localparam qword_t      Q_MIN    = 32'sh8000_0000;
  localparam qword_t      Q_ONE    = qword_t'(64'd1 << FRAC_BITS);

  logic [3:0]  st_r, st_nxt;
  logic        ph_r, ph_nxt;
  logic [1:0]  term_r, term_nxt;
  logic [1:0]  comp_r, comp_nxt;
  logic [1:0]  stage_r, stage_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        sat_r, sat_nxt;
  logic        ren_r, ren_nxt;

  qword_t q_r [4];
  qword_t q_nxt [4];
  qword_t t_r [4];
  qword_t t_nxt [4];
  qword_t w_r [4];
  qword_t w_nxt [4];
  tstep_t dt_r, dt_nxt;

  logic signed [K_W-1:0]   k_r [4];
  logic signed [K_W-1:0]   k_nxt [4];
  logic signed [KS_W-1:0]  ks_r [4];
  logic signed [KS_W-1:0]  ks_nxt [4];
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [P_W-1:0]   p_r;
  logic [43:0] d6_r, d6_nxt;
  logic [2:0]  rem6_r, rem6_nxt;
  logic [63:0] sqx_r, sqx_nxt;
  logic [63:0] res_r, res_nxt;
  logic [32:0] dnum_r, dnum_nxt;
  logic [32:0] drem_r, drem_nxt;

  logic signed [32:0]     mul_a, mul_b;
  logic signed [P_W-1:0]  mul_p;
  logic signed [KS_W-1:0] md_src;
  logic                   in_fire;

  function automatic logic [32:0] sat32(input logic signed [43:0] v);
    logic [32:0] sv;
    if (v > 44'sd2147483647) begin
      sv = {1'b1, Q_MAX};
    end else if (v < -44'sd2147483648) begin
      sv = {1'b1, Q_MIN};
    end else begin
      sv = {1'b0, v[31:0]};
    end
    return sv;
  endfunction

  assign in_chan.ready      = (st_r == S_IDLE);
  assign in_fire            = in_chan.valid & in_chan.ready;
  assign out_chan.valid     = (st_r == S_OUT);
  assign out_chan.out_q0    = q_r[0];
  assign out_chan.out_q1    = q_r[1];
  assign out_chan.out_q2    = q_r[2];
  assign out_chan.out_q3    = q_r[3];
  assign out_chan.saturated = sat_r;

  assign md_src = (stage_r == 2'd3) ? ks_r[comp_r]
                                    : KS_W'(k_r[comp_r]);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (st_r)
      S_DER: begin
        mul_a = 33'(t_r[term_r]);
        mul_b = 33'(w_r[comp_r ^ term_r]);
      end
      S_MD: begin
        mul_a = term_r[0] ? {12'd0, md_src[20:0]}
                          : {{12{md_src[KS_W-1]}}, md_src[KS_W-1:21]};
        mul_b = {1'b0, dt_r};
      end
      S_SQ: begin
        mul_a = 33'(q_r[comp_r]);
        mul_b = 33'(q_r[comp_r]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    logic signed [ACC_W-1:0] pm_ext;
    logic signed [K_W-1:0]   kv;
    logic signed [KS_W-1:0]  kext;
    logic signed [43:0]      sum44;
    logic [32:0]             sres;
    logic [4:0]              x6;
    logic [63:0]             sbit;
    logic [63:0]             tryv;
    logic [31:0]             mag;
    logic [31:0]             rdiv;
    logic [NUM_W-1:0]        num;
    logic [33:0]             dtry;
    logic                    ge;

    st_nxt    = st_r;
    ph_nxt    = ph_r;
    term_nxt  = term_r;
    comp_nxt  = comp_r;
    stage_nxt = stage_r;
    cnt_nxt   = cnt_r;
    sat_nxt   = sat_r;
    ren_nxt   = cfg_wr_en ? cfg_wr_data : ren_r;
    q_nxt     = q_r;
    t_nxt     = t_r;
    w_nxt     = w_r;
    dt_nxt    = dt_r;
    k_nxt     = k_r;
    ks_nxt    = ks_r;
    acc_nxt   = acc_r;
    d6_nxt    = d6_r;
    rem6_nxt  = rem6_r;
    sqx_nxt   = sqx_r;
    res_nxt   = res_r;
    dnum_nxt  = dnum_r;
    drem_nxt  = drem_r;

    pm_ext = ACC_W'(p_r >>> 25);
    kv     = K_W'(acc_r >>> 1);
    kext   = KS_W'(kv);
    sum44  = '0;
    sres   = '0;
    x6     = {rem6_r, d6_r[43:42]};
    sbit   = 64'd1 << {cnt_r[4:0], 1'b0};
    tryv   = res_r + sbit;
    rdiv   = res_r[31:0];
    mag    = q_r[comp_r][31] ? 32'(-q_r[comp_r]) : 32'(q_r[comp_r]);
    num    = NUM_W'(mag) << (FRAC_BITS - 1);
    dtry   = {drem_r, dnum_r[32]};
    ge     = (dtry >= 34'(rdiv));

    unique case (st_r)
      S_IDLE: begin
        if (in_fire) begin
          sat_nxt = 1'b0;
          if (in_chan.cmd == CMD_LOAD) begin
            q_nxt[0] = in_chan.rate_w0;
            q_nxt[1] = in_chan.rate_w1;
            q_nxt[2] = in_chan.rate_w2;
            q_nxt[3] = in_chan.rate_w3;
            st_nxt   = S_OUT;
          end else begin
            w_nxt[0]  = in_chan.rate_w0;
            w_nxt[1]  = in_chan.rate_w1;
            w_nxt[2]  = in_chan.rate_w2;
            w_nxt[3]  = in_chan.rate_w3;
            dt_nxt    = in_chan.step_time;
            t_nxt     = q_r;
            for (int i = 0; i < 4; i++) ks_nxt[i] = '0;
            acc_nxt   = '0;
            stage_nxt = 2'd0;
            comp_nxt  = 2'd0;
            term_nxt  = 2'd0;
            ph_nxt    = 1'b0;
            st_nxt    = S_DER;
          end
        end
      end
      S_DER: begin
        ph_nxt = ~ph_r;
        if (ph_r) begin
          acc_nxt = DER_NEG[{comp_r, term_r}] ? acc_r - pm_ext : acc_r + pm_ext;
          if (term_r == 2'd3) begin
            st_nxt = S_KFIN;
          end
          term_nxt = term_r + 2'd1;
        end
      end
      S_KFIN: begin
        k_nxt[comp_r]  = kv;
        ks_nxt[comp_r] = ks_r[comp_r] +
                         ((stage_r == 2'd1 || stage_r == 2'd2) ? (kext <<< 1) : kext);
        acc_nxt  = '0;
        term_nxt = 2'd0;
        ph_nxt   = 1'b0;
        comp_nxt = comp_r + 2'd1;
        st_nxt   = (comp_r == 2'd3) ? S_MD : S_DER;
      end
      S_MD: begin
        ph_nxt = ~ph_r;
        if (ph_r) begin
          if (term_r == 2'd0) begin
            acc_nxt  = ACC_W'(p_r);
            term_nxt = 2'd1;
          end else begin
            acc_nxt  = (acc_r <<< 21) + ACC_W'(p_r);
            term_nxt = 2'd0;
            st_nxt   = (stage_r == 2'd3) ? S_D6I : S_TFIN;
          end
        end
      end
      S_TFIN: begin
        sum44 = 44'(q_r[comp_r]) +
                ((stage_r == 2'd2) ? 44'(acc_r >>> 32) : 44'(acc_r >>> 33));
        sres  = sat32(sum44);
        t_nxt[comp_r] = sres[31:0];
        sat_nxt  = sat_r | sres[32];
        acc_nxt  = '0;
        comp_nxt = comp_r + 2'd1;
        if (comp_r == 2'd3) begin
          stage_nxt = stage_r + 2'd1;
          st_nxt    = S_DER;
        end else begin
          st_nxt = S_MD;
        end
      end
      S_D6I: begin
        d6_nxt   = 44'(acc_r >>> 32) + D6_BIAS;
        rem6_nxt = 3'd0;
        cnt_nxt  = 6'd21;
        st_nxt   = S_D6;
      end
      S_D6: begin
        priority if (x6 >= 5'd18) begin
          rem6_nxt = 3'(x6 - 5'd18);
          d6_nxt   = {d6_r[41:0], 2'd3};
        end else if (x6 >= 5'd12) begin
          rem6_nxt = 3'(x6 - 5'd12);
          d6_nxt   = {d6_r[41:0], 2'd2};
        end else if (x6 >= 5'd6) begin
          rem6_nxt = 3'(x6 - 5'd6);
          d6_nxt   = {d6_r[41:0], 2'd1};
        end else begin
          rem6_nxt = 3'(x6);
          d6_nxt   = {d6_r[41:0], 2'd0};
        end
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          st_nxt = S_QFIN;
        end
      end
      S_QFIN: begin
        sum44 = 44'(q_r[comp_r]) + signed'(d6_r - D6_QOFF);
        sres  = sat32(sum44);
        q_nxt[comp_r] = sres[31:0];
        sat_nxt  = sat_r | sres[32];
        acc_nxt  = '0;
        term_nxt = 2'd0;
        ph_nxt   = 1'b0;
        comp_nxt = comp_r + 2'd1;
        if (comp_r == 2'd3) begin
          sqx_nxt = '0;
          st_nxt  = ren_r ? S_SQ : S_OUT;
        end else begin
          st_nxt = S_MD;
        end
      end
      S_SQ: begin
        ph_nxt = ~ph_r;
        if (ph_r) begin
          sqx_nxt  = sqx_r + 64'(p_r >>> 2);
          comp_nxt = comp_r + 2'd1;
          if (comp_r == 2'd3) begin
            res_nxt = '0;
            cnt_nxt = 6'd31;
            st_nxt  = S_SQRT;
          end
        end
      end
      S_SQRT: begin
        if (sqx_r >= tryv) begin
          sqx_nxt = sqx_r - tryv;
          res_nxt = (res_r >> 1) + sbit;
        end else begin
          res_nxt = res_r >> 1;
        end
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          comp_nxt = 2'd0;
          st_nxt   = S_DCHK;
        end
      end
      S_DCHK: begin
        if (res_r == 64'd0) begin
          st_nxt = S_OUT;
        end else if (32'(num >> 33) >= rdiv) begin
          q_nxt[comp_r] = q_r[comp_r][31] ? Q_MIN : Q_MAX;
          sat_nxt  = 1'b1;
          comp_nxt = comp_r + 2'd1;
          if (comp_r == 2'd3) begin
            st_nxt = S_OUT;
          end
        end else begin
          drem_nxt = 33'(num >> 33);
          dnum_nxt = num[32:0];
          cnt_nxt  = 6'd32;
          st_nxt   = S_DIV;
        end
      end
      S_DIV: begin
        drem_nxt = ge ? 33'(dtry - 34'(rdiv)) : dtry[32:0];
        dnum_nxt = {dnum_r[31:0], ge};
        cnt_nxt  = cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          st_nxt = S_DFIN;
        end
      end
      S_DFIN: begin
        if (!q_r[comp_r][31]) begin
          if (dnum_r > 33'h0_7FFF_FFFF) begin
            q_nxt[comp_r] = Q_MAX;
            sat_nxt = 1'b1;
          end else begin
            q_nxt[comp_r] = dnum_r[31:0];
          end
        end else begin
          if (dnum_r > 33'h0_8000_0000) begin
            q_nxt[comp_r] = Q_MIN;
            sat_nxt = 1'b1;
          end else begin
            q_nxt[comp_r] = -dnum_r[31:0];
          end
        end
        comp_nxt = comp_r + 2'd1;
        st_nxt   = (comp_r == 2'd3) ? S_OUT : S_DCHK;
      end
      S_OUT: begin
        if (out_chan.ready) begin
          st_nxt = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      sat_r <= 1'b0;
      ren_r <= 1'b1;
      q_r[0] <= Q_ONE;
      q_r[1] <= '0;
      q_r[2] <= '0;
      q_r[3] <= '0;
    end else begin
      st_r  <= st_nxt;
      sat_r <= sat_nxt;
      ren_r <= ren_nxt;
      q_r   <= q_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ph_r    <= ph_nxt;
    term_r  <= term_nxt;
    comp_r  <= comp_nxt;
    stage_r <= stage_nxt;
    cnt_r   <= cnt_nxt;
    t_r     <= t_nxt;
    w_r     <= w_nxt;
    dt_r    <= dt_nxt;
    k_r     <= k_nxt;
    ks_r    <= ks_nxt;
    acc_r   <= acc_nxt;
    p_r     <= mul_p;
    d6_r    <= d6_nxt;
    rem6_r  <= rem6_nxt;
    sqx_r   <= sqx_nxt;
    res_r   <= res_nxt;
    dnum_r  <= dnum_nxt;
    drem_r  <= drem_nxt;
  end

endmodule

/* hw/rtl/qrk_checker.sv */
// ----------------------------------------------------------------------------
// qrk_checker: port-level checks for the quaternion RK4 integrator
// Watches the item channels of the top level; bound to it below.
// ----------------------------------------------------------------------------
module qrk_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_cmd,
  input logic out_valid,
  input logic out_ready,
  input logic out_sat
);
  import qrk_pkg::*;

  // one item in flight: never idle while a result waits
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while result pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready right after accept");

  a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_cmd == CMD_LOAD) |=> (out_valid && !out_sat))
    else $error("load item result wrong");

  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |=> in_ready)
    else $error("not idle after result taken");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

endmodule

bind quaternion_rk4_integrator_top qrk_checker u_qrk_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .in_cmd    (in_chan.cmd),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_sat   (out_chan.saturated)
);
